[src/lld_pkg.sv]
package lld_pkg;

  // Default number of drives tracked by the selector.
  localparam int unsigned LLD_NUM_DRIVES = 8;

  localparam int unsigned PENDING_W   = 16;
  localparam int unsigned BYTES_W     = 48;
  localparam int unsigned LATENCY_W   = 32;
  localparam int unsigned DRIVE_W     = 8;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned THRESHOLD_W = 16;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd16;
  localparam logic [PENDING_W-1:0]   PENDING_MAX     = '1;
  localparam logic [BYTES_W-1:0]     BYTES_MAX       = '1;

  typedef enum logic [1:0] {
    CMD_SELECT   = 2'd0,
    CMD_START    = 2'd1,
    CMD_COMPLETE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_UNDER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIM,
    S_SCAN
  } state_e;

  // One row of per-drive bookkeeping.
  typedef struct packed {
    logic [PENDING_W-1:0] pending;
    logic [BYTES_W-1:0]   bytes;
    logic [LATENCY_W-1:0] latency;
  } row_t;

  // Strobes from the sequencer to the drive table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

[src/lld_table.sv]
module lld_table #(
  parameter int unsigned NUM_DRIVES = lld_pkg::LLD_NUM_DRIVES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lld_pkg::mem_ctl_t                 ctl_i,
  input  logic [$clog2(NUM_DRIVES)-1:0]     rd_addr_i,
  input  logic [$clog2(NUM_DRIVES)-1:0]     wr_addr_i,
  input  lld_pkg::row_t                     wr_row_i,
  output lld_pkg::row_t                     rd_row_o
);
  import lld_pkg::*;

  row_t                  mem [NUM_DRIVES];
  logic [NUM_DRIVES-1:0] valid_q;
  logic                  rd_valid_q;
  row_t                  rd_data_q;

  // A row that was never written since reset reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_row_o = rd_valid_q ? rd_data_q : '0;

endmodule

[src/lld_unit.sv]
module lld_unit (
  input  lld_pkg::cmd_e                        cmd_i,
  input  lld_pkg::row_t                        row_i,
  input  logic [lld_pkg::SIZE_W-1:0]           size_i,
  input  logic [lld_pkg::LATENCY_W-1:0]        duration_i,
  input  logic [lld_pkg::PENDING_W-1:0]        cmp_ref_i,
  output lld_pkg::row_t                        row_o,
  output logic                                 underflow_o,
  output logic                                 lt_o
);
  import lld_pkg::*;

  logic [BYTES_W:0]   byte_sum;
  logic [LATENCY_W:0] lat_sum;

  // Shared compare: used against the threshold and against the running minimum.
  assign lt_o = row_i.pending < cmp_ref_i;

  assign byte_sum = {1'b0, row_i.bytes} + {{(BYTES_W + 1 - SIZE_W){1'b0}}, size_i};
  assign lat_sum  = {1'b0, row_i.latency} + {1'b0, duration_i};

  always_comb begin
    row_o       = row_i;
    underflow_o = 1'b0;
    case (cmd_i)
      CMD_START: begin
        if (row_i.pending != PENDING_MAX) begin
          row_o.pending = row_i.pending + 1'b1;
        end
      end
      CMD_COMPLETE: begin
        row_o.bytes   = byte_sum[BYTES_W] ? BYTES_MAX : byte_sum[BYTES_W-1:0];
        row_o.latency = lat_sum[LATENCY_W:1];
        if (row_i.pending == '0) begin
          underflow_o = 1'b1;
        end else begin
          row_o.pending = row_i.pending - 1'b1;
        end
      end
      default: begin
        row_o = row_i;
      end
    endcase
  end

endmodule

[src/least_loaded_drive_selector_core.sv]
// Least-loaded drive selector. The block keeps, for every drive, a count of
// pending operations, a saturating byte total and a running latency average
// in nanoseconds, all cleared by reset. A request is taken when start is high
// and busy is low. Start and complete requests, and a select request whose
// primary drive is below the busy threshold, raise busy while the drive's
// row is read from the table, and the result appears on the cycle after
// that. A select request whose primary drive is at or above the threshold
// then scans the pending counts one drive per cycle through the shared
// compare unit, holding busy until the last drive is compared; its result
// follows in the next cycle. A request with an unused command or with
// a drive index out of range touches no state, never raises busy, and its
// result appears on the next cycle. Each result is presented for exactly one
// cycle with done_o high; the receiver cannot hold it off, so it must take
// every result in that cycle. The busy threshold is written through its own
// valid/ready port, which is always ready, and should only be changed while
// no request is in flight.
module least_loaded_drive_selector_core #(
  parameter int unsigned NUM_DRIVES = lld_pkg::LLD_NUM_DRIVES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command_i,
  input  logic [lld_pkg::DRIVE_W-1:0]         drive_i,
  input  logic [lld_pkg::SIZE_W-1:0]          size_i,
  input  logic [lld_pkg::LATENCY_W-1:0]       duration_ns_i,
  output logic                                done_o,
  output logic [lld_pkg::DRIVE_W-1:0]         chosen_drive_o,
  output logic [1:0]                          status_o,
  output logic [lld_pkg::PENDING_W-1:0]       pending_now_o,
  output logic [lld_pkg::BYTES_W-1:0]         bytes_total_o,
  output logic [lld_pkg::LATENCY_W-1:0]       latency_average_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lld_pkg::THRESHOLD_W-1:0]     cfg_data_i
);
  import lld_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_DRIVES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DRIVES - 1);

  state_e                 state_q, state_d;
  cmd_e                   cmd_q, cmd_d;
  logic [IDX_W-1:0]       prim_q, prim_d;
  logic [SIZE_W-1:0]      size_q, size_d;
  logic [LATENCY_W-1:0]   dur_q, dur_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [PENDING_W-1:0]   least_q, least_d;
  logic [IDX_W-1:0]       best_q, best_d;
  row_t                   saved_q, saved_d;
  logic [THRESHOLD_W-1:0] threshold_q;

  logic                   done_q, done_d;
  logic [DRIVE_W-1:0]     chosen_q, chosen_d;
  status_e                status_q, status_d;
  row_t                   res_q, res_d;

  mem_ctl_t               mem_ctl;
  logic [IDX_W-1:0]       rd_addr;
  row_t                   rd_row;
  row_t                   upd_row;
  logic                   underflow;
  logic                   lt;
  logic [PENDING_W-1:0]   cmp_ref;
  logic                   accept;
  logic                   out_of_range;

  assign accept       = start && !busy;
  assign out_of_range = {1'b0, drive_i} >= (DRIVE_W + 1)'(NUM_DRIVES);

  lld_table #(
    .NUM_DRIVES(NUM_DRIVES)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(prim_q),
    .wr_row_i (upd_row),
    .rd_row_o (rd_row)
  );

  lld_unit u_unit (
    .cmd_i      (cmd_q),
    .row_i      (rd_row),
    .size_i     (size_q),
    .duration_i (dur_q),
    .cmp_ref_i  (cmp_ref),
    .row_o      (upd_row),
    .underflow_o(underflow),
    .lt_o       (lt)
  );

  // The threshold register accepts a write on every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      threshold_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Request and result payload needs no reset.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    prim_q   <= prim_d;
    size_q   <= size_d;
    dur_q    <= dur_d;
    idx_q    <= idx_d;
    least_q  <= least_d;
    best_q   <= best_d;
    saved_q  <= saved_d;
    chosen_q <= chosen_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  // Sequencer: reject, or read the primary row, then finish or scan all drives.
  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    prim_d        = prim_q;
    size_d        = size_q;
    dur_d         = dur_q;
    idx_d         = idx_q;
    least_d       = least_q;
    best_d        = best_q;
    saved_d       = saved_q;
    chosen_d      = chosen_q;
    status_d      = status_q;
    res_d         = res_q;
    done_d        = 1'b0;
    mem_ctl       = '0;
    rd_addr       = idx_q;
    cmp_ref       = least_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_e'(command_i);
          prim_d = drive_i[IDX_W-1:0];
          size_d = size_i;
          dur_d  = duration_ns_i;
          if (!(command_i inside {CMD_SELECT, CMD_START, CMD_COMPLETE})) begin
            // Unused command: nothing changes and the result is all zero.
            chosen_d = '0;
            status_d = STAT_OK;
            res_d    = '0;
            done_d   = 1'b1;
          end else if (out_of_range) begin
            chosen_d = '0;
            status_d = STAT_RANGE;
            res_d    = '0;
            done_d   = 1'b1;
          end else begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = drive_i[IDX_W-1:0];
            state_d       = S_PRIM;
          end
        end
      end

      S_PRIM: begin
        cmp_ref = threshold_q;
        case (cmd_q)
          CMD_SELECT: begin
            if (lt) begin
              chosen_d = DRIVE_W'(prim_q);
              status_d = STAT_OK;
              res_d    = rd_row;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              // Primary is busy: start the scan at drive zero with the
              // primary as the current best.
              saved_d       = rd_row;
              least_d       = rd_row.pending;
              best_d        = prim_q;
              idx_d         = '0;
              mem_ctl.rd_en = 1'b1;
              rd_addr       = '0;
              state_d       = S_SCAN;
            end
          end
          CMD_START, CMD_COMPLETE: begin
            mem_ctl.wr_en = 1'b1;
            chosen_d      = '0;
            status_d      = underflow ? STAT_UNDER : STAT_OK;
            res_d         = upd_row;
            done_d        = 1'b1;
            state_d       = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        // Only a strictly smaller count replaces the best drive.
        if (lt) begin
          least_d = rd_row.pending;
          best_d  = idx_q;
        end
        if (idx_q == LAST_IDX) begin
          chosen_d = DRIVE_W'(best_d);
          status_d = STAT_OK;
          res_d    = saved_q;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          idx_d         = idx_q + 1'b1;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign chosen_drive_o    = chosen_q;
  assign status_o          = status_q;
  assign pending_now_o     = res_q.pending;
  assign bytes_total_o     = res_q.bytes;
  assign latency_average_o = res_q.latency;

`ifndef SYNTHESIS
  // A scan is only ever entered for a select request.
  a_scan_is_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cmd_q == CMD_SELECT))
    else $error("drive scan running for a request other than select");

  // A range error reports an all-zero result.
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_RANGE) |->
      (chosen_drive_o == '0 && pending_now_o == '0 && bytes_total_o == '0 &&
       latency_average_o == '0))
    else $error("range error result carries nonzero fields");

  // An underflow leaves the pending count at zero.
  a_under_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_UNDER) |-> (pending_now_o == '0))
    else $error("underflow reported with nonzero pending count");

  // A request that reads the table never finishes in the cycle after accept.
  a_table_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_of_range &&
     (command_i == CMD_SELECT || command_i == CMD_START ||
      command_i == CMD_COMPLETE)) |=> (busy && !done_o))
    else $error("table request finished without a table read");
`endif

endmodule
